// ===== rtl/core/hrrp_pkg.sv =====
// Shared types and constants for the health-aware round-robin link picker.
// Used by hrrp_alu, hrrp_store, hrrp_ctrl and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrrp_pkg;

	localparam int MAX_LINKS = 8;
	localparam int LINK_W    = 3;
	localparam int CNT_W     = 4;
	localparam int FAIL_W    = 8;
	localparam int SENT_W    = 16;
	localparam int BYTE_W    = 64;
	localparam int CFG_W     = 8;

	localparam logic [FAIL_W-1:0] FAIL_SAT    = 8'hFF;
	localparam logic [FAIL_W-1:0] LIMIT_RESET = 8'd5;

	// Configuration register indexes
	localparam logic CFG_LINK_COUNT = 1'b0;
	localparam logic CFG_FAIL_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		OP_PICK       = 2'd0,
		OP_REPORT     = 2'd1,
		OP_SET_HEALTH = 2'd2,
		OP_QUERY      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_HEALTHY  = 2'd1,
		ST_NOT_IN_USE  = 2'd2
	} status_t;

	// Request to and response from the shared add/subtract unit
	typedef struct packed {
		logic              sub;
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] res;
		logic              carry;
	} alu_rsp_t;

	// Write command into the link state store
	typedef struct packed {
		logic [LINK_W-1:0]    addr;
		logic                 we_fail;
		logic [FAIL_W-1:0]    fail_wdata;
		logic                 we_bytes;
		logic [BYTE_W-1:0]    bytes_wdata;
		logic                 we_total;
		logic [BYTE_W-1:0]    total_wdata;
		logic                 we_health;
		logic [MAX_LINKS-1:0] health_wdata;
	} store_cmd_t;

	// Read view of the link state at the commanded address
	typedef struct packed {
		logic [FAIL_W-1:0]    fail;
		logic [BYTE_W-1:0]    bytes;
		logic [BYTE_W-1:0]    total;
		logic [MAX_LINKS-1:0] health;
	} store_view_t;

endpackage

`default_nettype wire

// ===== rtl/core/hrrp_alu.sv =====
// Shared 64-bit add/subtract unit with carry/borrow out.
// Depends on hrrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrrp_alu (
	input  wire hrrp_pkg::alu_req_t req,
	output hrrp_pkg::alu_rsp_t      rsp
);
	import hrrp_pkg::*;

	logic [BYTE_W:0] wide;

	// Borrow on subtract means a < b
	always_comb begin
		if (req.sub) begin
			wide = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			wide = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.res   = wide[BYTE_W-1:0];
		rsp.carry = wide[BYTE_W];
	end

endmodule

`default_nettype wire

// ===== rtl/core/hrrp_store.sv =====
// Link state: health flags, failure counts, per-link and total byte counters.
// Depends on hrrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrrp_store (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire hrrp_pkg::store_cmd_t  cmd,
	output hrrp_pkg::store_view_t      view
);
	import hrrp_pkg::*;

	logic [MAX_LINKS-1:0] health_q;
	logic [FAIL_W-1:0]    fail_q  [MAX_LINKS];
	logic [BYTE_W-1:0]    bytes_q [MAX_LINKS];
	logic [BYTE_W-1:0]    total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= '1;
			total_q  <= '0;
			for (int i = 0; i < MAX_LINKS; i++) begin
				fail_q[i]  <= '0;
				bytes_q[i] <= '0;
			end
		end else begin
			if (cmd.we_health) begin
				health_q <= cmd.health_wdata;
			end
			if (cmd.we_fail) begin
				fail_q[cmd.addr] <= cmd.fail_wdata;
			end
			if (cmd.we_bytes) begin
				bytes_q[cmd.addr] <= cmd.bytes_wdata;
			end
			if (cmd.we_total) begin
				total_q <= cmd.total_wdata;
			end
		end
	end

	assign view.fail   = fail_q[cmd.addr];
	assign view.bytes  = bytes_q[cmd.addr];
	assign view.total  = total_q;
	assign view.health = health_q;

endmodule

`default_nettype wire

// ===== rtl/core/hrrp_ctrl.sv =====
// Sequencer, configuration registers and result register of the link picker.
// Depends on hrrp_pkg; drives hrrp_alu and hrrp_store through their structs.
`timescale 1ns / 1ps
`default_nettype none

module hrrp_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire                         cfg_index,
	input  wire [hrrp_pkg::CFG_W-1:0]   cfg_data,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire [1:0]                   op,
	input  wire [hrrp_pkg::LINK_W-1:0]  link,
	input  wire [hrrp_pkg::SENT_W-1:0]  sent_bytes,
	input  wire                         healthy_flag,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [1:0]                  status,
	output logic [hrrp_pkg::LINK_W-1:0] chosen_link,
	output logic [hrrp_pkg::FAIL_W-1:0] link_failures,
	output logic [hrrp_pkg::BYTE_W-1:0] link_bytes,
	output logic [hrrp_pkg::BYTE_W-1:0] total_bytes,
	output logic [hrrp_pkg::MAX_LINKS-1:0] health_mask,
	output hrrp_pkg::alu_req_t          alu_req,
	input  wire hrrp_pkg::alu_rsp_t     alu_rsp,
	output hrrp_pkg::store_cmd_t        store_cmd,
	input  wire hrrp_pkg::store_view_t  store_view
);
	import hrrp_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_REDUCE    = 7'b0000010,
		S_SCAN      = 7'b0000100,
		S_ADD_LINK  = 7'b0001000,
		S_ADD_TOTAL = 7'b0010000,
		S_UPDATE    = 7'b0100000,
		S_FINISH    = 7'b1000000
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [SENT_W-1:0]  sent_q;
	logic               flag_q;
	logic [LINK_W-1:0]  sel_q;
	logic [LINK_W-1:0]  idx_q;
	logic [CNT_W-1:0]   step_q;
	logic [LINK_W-1:0]  rr_ptr_q;
	status_t            pend_status_q;
	logic               zero_q;
	logic [CNT_W-1:0]   link_count_q;
	logic [FAIL_W-1:0]  fail_limit_q;

	logic               out_valid_q;
	logic               load;
	status_t            out_status_q;
	logic [LINK_W-1:0]  out_link_q;
	logic [FAIL_W-1:0]  out_fail_q;
	logic [BYTE_W-1:0]  out_bytes_q;
	logic [BYTE_W-1:0]  out_total_q;
	logic [MAX_LINKS-1:0] out_health_q;

	logic [CNT_W-1:0]   n_links;
	logic [CNT_W-1:0]   idx_inc;
	logic [LINK_W-1:0]  idx_wrap;
	logic [CNT_W-1:0]   step_inc;
	logic [FAIL_W-1:0]  fail_inc;
	logic [MAX_LINKS-1:0] link_bit;
	op_t                in_op;

	assign n_links  = (link_count_q > CNT_W'(MAX_LINKS)) ? CNT_W'(MAX_LINKS) : link_count_q;
	assign idx_inc  = alu_rsp.res[CNT_W-1:0];
	assign idx_wrap = (idx_inc == n_links) ? '0 : idx_inc[LINK_W-1:0];
	assign step_inc = step_q + CNT_W'(1);
	assign fail_inc = (store_view.fail != FAIL_SAT) ? store_view.fail + FAIL_W'(1)
		: store_view.fail;
	assign link_bit = MAX_LINKS'(1) << sel_q;
	assign in_op    = op_t'(op);
	assign in_stall = (state_q != S_IDLE);
	assign load     = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	// Route the shared unit by state
	always_comb begin
		alu_req.sub = 1'b0;
		alu_req.a   = '0;
		alu_req.b   = '0;
		case (state_q)
			S_REDUCE: begin
				alu_req.sub = 1'b1;
				alu_req.a   = BYTE_W'(idx_q);
				alu_req.b   = BYTE_W'(n_links);
			end
			S_SCAN: begin
				alu_req.a = BYTE_W'(idx_q);
				alu_req.b = BYTE_W'(1);
			end
			S_ADD_LINK: begin
				alu_req.a = store_view.bytes;
				alu_req.b = BYTE_W'(sent_q);
			end
			S_ADD_TOTAL: begin
				alu_req.a = store_view.total;
				alu_req.b = BYTE_W'(sent_q);
			end
			default: begin
			end
		endcase
	end

	// Store writes
	always_comb begin
		store_cmd.addr         = sel_q;
		store_cmd.we_fail      = 1'b0;
		store_cmd.fail_wdata   = fail_inc;
		store_cmd.we_bytes     = (state_q == S_ADD_LINK);
		store_cmd.bytes_wdata  = alu_rsp.res;
		store_cmd.we_total     = (state_q == S_ADD_TOTAL);
		store_cmd.total_wdata  = alu_rsp.res;
		store_cmd.we_health    = 1'b0;
		store_cmd.health_wdata = store_view.health & ~link_bit;
		if (state_q == S_UPDATE) begin
			case (op_q)
				OP_REPORT: begin
					store_cmd.we_fail   = 1'b1;
					store_cmd.we_health = (fail_inc >= fail_limit_q);
				end
				OP_SET_HEALTH: begin
					store_cmd.we_health = 1'b1;
					if (flag_q) begin
						store_cmd.health_wdata = store_view.health | link_bit;
						store_cmd.we_fail      = 1'b1;
						store_cmd.fail_wdata   = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_count_q <= '0;
			fail_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINK_COUNT: link_count_q <= cfg_data[CNT_W-1:0];
				CFG_FAIL_LIMIT: fail_limit_q <= cfg_data[FAIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rr_ptr_q      <= '0;
			out_valid_q   <= 1'b0;
			op_q          <= OP_PICK;
			sent_q        <= '0;
			flag_q        <= 1'b0;
			sel_q         <= '0;
			idx_q         <= '0;
			step_q        <= '0;
			pend_status_q <= ST_OK;
			zero_q        <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= in_op;
						sent_q <= sent_bytes;
						flag_q <= healthy_flag;
						if (in_op == OP_PICK) begin
							if (n_links == '0) begin
								pend_status_q <= ST_NO_HEALTHY;
								zero_q        <= 1'b1;
								sel_q         <= '0;
								state_q       <= S_FINISH;
							end else begin
								idx_q   <= rr_ptr_q;
								state_q <= S_REDUCE;
							end
						end else if (CNT_W'(link) >= n_links) begin
							pend_status_q <= ST_NOT_IN_USE;
							zero_q        <= 1'b1;
							sel_q         <= link;
							state_q       <= S_FINISH;
						end else begin
							pend_status_q <= ST_OK;
							zero_q        <= 1'b0;
							sel_q         <= link;
							if (in_op == OP_REPORT && sent_bytes != '0) begin
								state_q <= S_ADD_LINK;
							end else begin
								state_q <= S_UPDATE;
							end
						end
					end
				end
				S_REDUCE: begin
					// Subtract the link count until the start index is in range
					if (!alu_rsp.carry) begin
						idx_q <= alu_rsp.res[LINK_W-1:0];
					end else begin
						step_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (store_view.health[idx_q]) begin
						sel_q         <= idx_q;
						rr_ptr_q      <= idx_wrap;
						pend_status_q <= ST_OK;
						zero_q        <= 1'b0;
						state_q       <= S_FINISH;
					end else if (step_inc == n_links) begin
						sel_q         <= '0;
						pend_status_q <= ST_NO_HEALTHY;
						zero_q        <= 1'b1;
						state_q       <= S_FINISH;
					end else begin
						idx_q  <= idx_wrap;
						step_q <= step_inc;
					end
				end
				S_ADD_LINK: begin
					state_q <= S_ADD_TOTAL;
				end
				S_ADD_TOTAL: begin
					state_q <= S_FINISH;
				end
				S_UPDATE: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= pend_status_q;
			out_link_q   <= sel_q;
			out_fail_q   <= zero_q ? '0 : store_view.fail;
			out_bytes_q  <= zero_q ? '0 : store_view.bytes;
			out_total_q  <= store_view.total;
			out_health_q <= store_view.health;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign chosen_link   = out_link_q;
	assign link_failures = out_fail_q;
	assign link_bytes    = out_bytes_q;
	assign total_bytes   = out_total_q;
	assign health_mask   = out_health_q;

	a_reduce_has_links: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REDUCE) |-> (n_links != '0))
		else $error("start reduction with no links in use");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (step_q < n_links && CNT_W'(idx_q) < n_links))
		else $error("scan ran past the links in use");

	a_pointer_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && store_view.health[idx_q]) |=> (CNT_W'(rr_ptr_q) < n_links))
		else $error("round-robin pointer left the links in use");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> (out_fail_q == '0 && out_bytes_q == '0))
		else $error("failed item carries link counters");

endmodule

`default_nettype wire

// ===== rtl/core/health_aware_round_robin_picker_top.sv =====
// Top level of the health-aware round-robin link picker.
// Depends on hrrp_pkg, hrrp_alu, hrrp_store and hrrp_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per transfer. op selects pick,
//   report attempt, set health or a read-only query; link, sent_bytes and
//   healthy_flag are the operands.
//   Output channel (out_valid / out_stall): exactly one result per item, in order.
//   Configuration: cfg_we writes cfg_data to link_count (index 0) or
//   failure_limit (index 1); write only while no item is in flight.
//   Sequence after the input transfer: a link outside the count or a pick with
//   no links goes straight to finish; set health, query and failed reports
//   pass through the update state; a successful report through the link add
//   and total add states (one add for the link counter, one for the total,
//   both on the single shared 64-bit adder). A pick takes one subtract step
//   per whole link count held in the start pointer plus a closing compare,
//   then a scan step per link flag examined; steps and flags together never exceed 8.
//   Throughput: one item at a time; in_stall stays high from the transfer
//   until the result is loaded into the output register. The next item is
//   taken while that result still waits to be collected.
//   Reset: all links healthy, counters and pointer zero, link_count 0,
//   failure_limit 5. No clearing pass is needed.
//   Receiver stall: the result holds in the output register; a finished
//   sequencer waits for the register to free before going idle.
`timescale 1ns / 1ps
`default_nettype none

module health_aware_round_robin_picker_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  op,
	input  wire  [2:0]  link,
	input  wire  [15:0] sent_bytes,
	input  wire         healthy_flag,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [2:0]  chosen_link,
	output logic [7:0]  link_failures,
	output logic [63:0] link_bytes,
	output logic [63:0] total_bytes,
	output logic [7:0]  health_mask
);
	import hrrp_pkg::*;

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;
	store_cmd_t  store_cmd;
	store_view_t store_view;

	// Shared adder: pointer reduction, scan stepping and both byte additions
	hrrp_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Per-link health, failures and byte counters plus the grand total
	hrrp_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (store_cmd),
		.view   (store_view)
	);

	// Sequencer, configuration and result register
	hrrp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.link          (link),
		.sent_bytes    (sent_bytes),
		.healthy_flag  (healthy_flag),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.chosen_link   (chosen_link),
		.link_failures (link_failures),
		.link_bytes    (link_bytes),
		.total_bytes   (total_bytes),
		.health_mask   (health_mask),
		.alu_req       (alu_req),
		.alu_rsp       (alu_rsp),
		.store_cmd     (store_cmd),
		.store_view    (store_view)
	);

endmodule

`default_nettype wire

// ===== verif/picker_result_checker.sv =====
// Result checker for the health-aware round-robin link picker.
// Watches both channels and the register port, predicts each result, compares.
// Depends on hrrp_pkg.
`timescale 1ns / 1ps

module picker_result_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  op,
	input  wire  [2:0]  link,
	input  wire  [15:0] sent_bytes,
	input  wire         healthy_flag,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [1:0]  status,
	input  wire  [2:0]  chosen_link,
	input  wire  [7:0]  link_failures,
	input  wire  [63:0] link_bytes,
	input  wire  [63:0] total_bytes,
	input  wire  [7:0]  health_mask,
	output int          mismatch_count,
	output int          answers_pending
);
	import hrrp_pkg::*;

	typedef struct {
		status_t           status;
		logic [LINK_W-1:0] chosen;
		logic [FAIL_W-1:0] fails;
		logic [BYTE_W-1:0] bytes;
		logic [BYTE_W-1:0] total;
		logic [7:0]        mask;
	} picker_answer_t;

	// Mirror of the link table and registers
	logic [MAX_LINKS-1:0] healthy;
	logic [FAIL_W-1:0]    fail_cnt [MAX_LINKS];
	logic [BYTE_W-1:0]    byte_cnt [MAX_LINKS];
	logic [BYTE_W-1:0]    grand;
	int                   rr_ptr;
	logic [CNT_W-1:0]     links_cfg;
	logic [FAIL_W-1:0]    fail_limit;

	picker_answer_t answers_due [$];
	int             results_seen = 0;

	task automatic flag_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		$display("mismatch on result %0d: %s expected 0x%0h, got 0x%0h",
			results_seen, what, want_v, got_v);
		mismatch_count++;
	endtask

	// Apply one item to the mirrored table and return the answer it should produce
	function automatic picker_answer_t next_answer(op_t kind, logic [LINK_W-1:0] lk,
			logic [SENT_W-1:0] sent, logic flag);
		picker_answer_t a;
		int  span;
		int  idx;
		bit  found;
		span     = (links_cfg > MAX_LINKS) ? MAX_LINKS : int'(links_cfg);
		a.status = ST_OK;
		a.chosen = lk;
		a.fails  = '0;
		a.bytes  = '0;
		found    = 1'b0;
		if (kind == OP_PICK) begin
			a.status = ST_NO_HEALTHY;
			a.chosen = '0;
			for (int i = 0; i < span && !found; i++) begin
				idx = (rr_ptr + i) % span;
				if (healthy[idx]) begin
					found    = 1'b1;
					a.chosen = idx[LINK_W-1:0];
					rr_ptr   = (idx + 1) % span;
				end
			end
			if (found) begin
				a.status = ST_OK;
				a.fails  = fail_cnt[a.chosen];
				a.bytes  = byte_cnt[a.chosen];
			end
		end else if (int'(lk) >= span) begin
			a.status = ST_NOT_IN_USE;
		end else begin
			if (kind == OP_REPORT) begin
				if (sent != '0) begin
					byte_cnt[lk] = byte_cnt[lk] + 64'(sent);
					grand        = grand + 64'(sent);
				end else begin
					if (fail_cnt[lk] != FAIL_SAT)
						fail_cnt[lk] = fail_cnt[lk] + 1'b1;
					if (fail_cnt[lk] >= fail_limit)
						healthy[lk] = 1'b0;
				end
			end else if (kind == OP_SET_HEALTH) begin
				healthy[lk] = flag;
				if (flag)
					fail_cnt[lk] = '0;
			end
			a.fails = fail_cnt[lk];
			a.bytes = byte_cnt[lk];
		end
		a.total = grand;
		a.mask  = healthy;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		picker_answer_t want;
		if (!arst_n) begin
			mismatch_count = 0;
			healthy    = '1;
			grand      = '0;
			rr_ptr     = 0;
			links_cfg  = '0;
			fail_limit = LIMIT_RESET;
			for (int i = 0; i < MAX_LINKS; i++) begin
				fail_cnt[i] = '0;
				byte_cnt[i] = '0;
			end
			answers_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					flag_mismatch("result with nothing outstanding", '0, '0);
				end else begin
					want = answers_due.pop_front();
					if (status != want.status)
						flag_mismatch("status", want.status, status);
					if (chosen_link != want.chosen)
						flag_mismatch("chosen_link", want.chosen, chosen_link);
					if (link_failures != want.fails)
						flag_mismatch("link_failures", want.fails, link_failures);
					if (link_bytes != want.bytes)
						flag_mismatch("link_bytes", want.bytes, link_bytes);
					if (total_bytes != want.total)
						flag_mismatch("total_bytes", want.total, total_bytes);
					if (health_mask != want.mask)
						flag_mismatch("health_mask", want.mask, health_mask);
				end
				results_seen++;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_LINK_COUNT)
					links_cfg = cfg_data[CNT_W-1:0];
				else
					fail_limit = cfg_data;
			end
			if (in_valid && !in_stall)
				answers_due.push_back(next_answer(op_t'(op), link, sent_bytes, healthy_flag));
		end
		answers_pending = answers_due.size();
	end

endmodule

// ===== verif/tb_health_aware_round_robin_picker_top.sv =====
// Testbench top for the health-aware round-robin link picker.
// Drives items, register writes and receiver stalls; gives the verdict.
// Depends on hrrp_pkg, health_aware_round_robin_picker_top and picker_result_checker.
`timescale 1ns / 1ps

module tb_health_aware_round_robin_picker_top;

	import hrrp_pkg::*;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic        cfg_index    = CFG_LINK_COUNT;
	logic [7:0]  cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [1:0]  op           = OP_PICK;
	logic [2:0]  link         = '0;
	logic [15:0] sent_bytes   = '0;
	logic        healthy_flag = 1'b0;
	logic        out_valid;
	logic        out_stall    = 1'b1;
	logic [1:0]  status;
	logic [2:0]  chosen_link;
	logic [7:0]  link_failures;
	logic [63:0] link_bytes;
	logic [63:0] total_bytes;
	logic [7:0]  health_mask;

	int mismatch_count;
	int answers_pending;

	// Pacing knobs: 1 draws a random gap per transfer, 0 runs back to back
	bit tx_pace     = 1'b1;
	bit rx_pace     = 1'b1;
	// Ask the receiver for one long hold-off so the block backs up into its input
	bit rx_hold_req = 1'b0;

	health_aware_round_robin_picker_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.link         (link),
		.sent_bytes   (sent_bytes),
		.healthy_flag (healthy_flag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.chosen_link  (chosen_link),
		.link_failures(link_failures),
		.link_bytes   (link_bytes),
		.total_bytes  (total_bytes),
		.health_mask  (health_mask)
	);

	picker_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.link           (link),
		.sent_bytes     (sent_bytes),
		.healthy_flag   (healthy_flag),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.chosen_link    (chosen_link),
		.link_failures  (link_failures),
		.link_bytes     (link_bytes),
		.total_bytes    (total_bytes),
		.health_mask    (health_mask),
		.mismatch_count (mismatch_count),
		.answers_pending(answers_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: several times the slowest legal run, including the long hold-off
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// Receiver: per transfer, hold stall for a drawn number of cycles, then drop it
	// and wait for the transfer. A pending hold request replaces one draw.
	initial begin : receiver
		int gap;
		bit hold_taken;
		hold_taken = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = rx_pace ? $urandom_range(0, 18) : 0;
			if (rx_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				gap = 300;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Write one register; call at a falling edge, returns at a falling edge
	task automatic write_reg(logic idx, logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Offer one item and hold it until the transfer; call at a falling edge
	task automatic send_item(op_t kind, logic [2:0] lk, logic [15:0] sent, logic flag);
		int gap;
		gap = tx_pace ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		op           <= kind;
		link         <= lk;
		sent_bytes   <= sent;
		healthy_flag <= flag;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result has been collected
	task automatic drain;
		in_valid <= 1'b0;
		while (answers_pending != 0) @(negedge clk);
	endtask

	// Program both registers; the upper nibble of the link count write is don't-care
	task automatic program_links(logic [3:0] count, logic [7:0] limit);
		write_reg(CFG_LINK_COUNT, {4'($urandom_range(0, 15)), count});
		write_reg(CFG_FAIL_LIMIT, limit);
	endtask

	// One random item: mostly links in use, occasionally any index as noise
	task automatic send_random(int span, int fail_pct);
		int          roll;
		op_t         kind;
		logic [2:0]  lk;
		logic [15:0] sent;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			kind = OP_PICK;
		else if (roll < 75)
			kind = OP_REPORT;
		else if (roll < 90)
			kind = OP_SET_HEALTH;
		else
			kind = OP_QUERY;
		if (span > 0 && $urandom_range(0, 9) != 0)
			lk = 3'($urandom_range(0, span - 1));
		else
			lk = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 99) < fail_pct)
			sent = '0;
		else case ($urandom_range(0, 2))
			0:       sent = 16'hFFFF;
			1:       sent = 16'($urandom_range(1, 255));
			default: sent = 16'($urandom_range(1, 65535));
		endcase
		send_item(kind, lk, sent, $urandom_range(0, 9) < 7);
	endtask

	// Settle, reprogram, then run a batch of random items at the given pacing
	task automatic run_phase(logic [3:0] count, logic [7:0] limit, int items,
			int fail_pct, bit txp, bit rxp);
		int span;
		drain();
		program_links(count, limit);
		span    = (count > MAX_LINKS) ? MAX_LINKS : int'(count);
		tx_pace = txp;
		rx_pace = rxp;
		for (int i = 0; i < items; i++)
			send_random(span, fail_pct);
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings, no links in use: pick finds nothing, the rest are out of range
		send_item(OP_PICK, 3'd0, 16'h0000, 1'b0);
		send_item(OP_REPORT, 3'd7, 16'hFFFF, 1'b1);
		send_item(OP_SET_HEALTH, 3'd0, 16'h0000, 1'b0);
		send_item(OP_QUERY, 3'd3, 16'h1234, 1'b1);

		// Count above the maximum acts as eight; limit two
		drain();
		program_links(4'd15, 8'd2);
		repeat (5) send_item(OP_PICK, 3'd0, 16'h0000, 1'b0);
		send_item(OP_REPORT, 3'd7, 16'hFFFF, 1'b0);
		send_item(OP_REPORT, 3'd7, 16'h0000, 1'b0);
		send_item(OP_REPORT, 3'd7, 16'h0000, 1'b1);
		send_item(OP_QUERY, 3'd7, 16'h0000, 1'b0);
		send_item(OP_REPORT, 3'd6, 16'h0001, 1'b0);

		// Two links, limit zero: pointer sits beyond the count, one failure kills a
		// link, then no link is healthy until one is revived
		drain();
		program_links(4'd2, 8'd0);
		send_item(OP_PICK, 3'd7, 16'hFFFF, 1'b1);
		send_item(OP_REPORT, 3'd1, 16'h0000, 1'b1);
		send_item(OP_SET_HEALTH, 3'd0, 16'hFFFF, 1'b0);
		send_item(OP_PICK, 3'd0, 16'h0000, 1'b0);
		send_item(OP_SET_HEALTH, 3'd5, 16'h0000, 1'b1);
		send_item(OP_SET_HEALTH, 3'd1, 16'h0000, 1'b1);
		send_item(OP_PICK, 3'd0, 16'h0000, 1'b0);
		send_item(OP_QUERY, 3'd0, 16'h0000, 1'b0);

		// Random phases over a spread of settings; the first one also gets the
		// long receiver hold-off while the sender keeps offering
		rx_hold_req = 1'b1;
		run_phase(4'd8, 8'd5, 150, 25, 1'b1, 1'b1);
		run_phase(4'd3, 8'd1, 120, 30, 1'b0, 1'b0);
		run_phase(4'd15, 8'd255, 120, 20, 1'b1, 1'b0);

		// One link at the top limit: hammer it with failed attempts until the
		// failure count saturates, with the odd success mixed in
		drain();
		program_links(4'd1, 8'd255);
		tx_pace = 1'b0;
		rx_pace = 1'b1;
		for (int i = 0; i < 270; i++)
			send_item(OP_REPORT, 3'd0,
				($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000,
				1'($urandom_range(0, 1)));
		send_item(OP_PICK, 3'd0, 16'h0000, 1'b0);
		send_item(OP_QUERY, 3'd0, 16'h0000, 1'b0);

		run_phase(4'd0, 8'd0, 40, 30, 1'b1, 1'b1);
		run_phase(4'd6, 8'd0, 120, 20, 1'b0, 1'b1);
		run_phase(4'd8, 8'd3, 150, 30, 1'b1, 1'b1);
		run_phase(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 100, 25,
			1'b1, 1'b1);

		// Collect everything, let the sequencer settle, then decide
		drain();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
